// ===== hw/rtl/bmm_pkg.sv =====
// shared types and constants for the 3x3 mirror-border box mean
package bmm_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned ROW_W     = 12;
  localparam int unsigned COL_W     = 10;
  localparam int unsigned WCFG_W    = 11;
  localparam int unsigned HCFG_W    = 13;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned SUM_W     = 12;
  localparam int unsigned RECIP_W   = 13;
  localparam int unsigned PROD_W    = SUM_W + RECIP_W;
  localparam int unsigned MEAN_LSB  = 16;

  // sum / 9 as (sum * 7282) >> 16, exact for sums up to 9 * 255
  localparam logic [RECIP_W-1:0] MEAN_RECIP = 13'd7282;

  localparam logic [WCFG_W-1:0] WIDTH_RESET  = 11'd512;
  localparam logic [HCFG_W-1:0] HEIGHT_RESET = 13'd512;

  // result kinds, as bit positions of the per-item result mask
  localparam int unsigned RES_UP_LEFT    = 0;
  localparam int unsigned RES_UP_EDGE    = 1;
  localparam int unsigned RES_LAST_LEFT  = 2;
  localparam int unsigned RES_LAST_EDGE  = 3;
  localparam int unsigned RES_KINDS      = 4;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } bmm_reg_t;

  typedef logic [2:0][2:0][PIX_W-1:0] bmm_window_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } bmm_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] mean_value;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             last_of_run;
  } bmm_out_t;

  typedef struct packed {
    bmm_window_t          window;
    logic [ROW_W-1:0]     row_cur;
    logic [ROW_W-1:0]     row_prev;
    logic [COL_W-1:0]     col_cur;
    logic [COL_W-1:0]     col_prev;
    logic                 top_mirror;
    logic                 left_mirror;
    logic [RES_KINDS-1:0] res_mask;
  } bmm_item_t;

endpackage

// ===== hw/rtl/box_mean_3x3_mirror_border_unit.sv =====
// top level of the 3x3 box mean with mirror borders
// Streams 8-bit grey pixels in raster order and returns the truncated 3x3
// mean of every pixel, with borders mirrored without repeating the edge
// pixel. A pixel transfer is taken every cycle while the two-entry queue has
// room; the result side delivers one result per cycle while res_ready is
// high, and a pixel holds the back end until all results it causes are out
// (one result inside the image, two at a row end or on the last row, four at
// the final pixel of a frame). Results come out one row and one column
// behind the pixel that causes them. Two lines of history sit in one
// MAX_WIDTH x 16 bit buffer with one read and one write port. Width and
// height are to be written only while the unit is idle, which the unit does
// not enforce, and are held to 2..MAX_WIDTH and 2..MAX_HEIGHT; frame_start
// moves the position to row 0, column 0.
module box_mean_3x3_mirror_border_unit #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pix_valid,
  output logic                        pix_ready,
  input  bmm_pkg::bmm_in_t            pix,
  output logic                        res_valid,
  input  logic                        res_ready,
  output bmm_pkg::bmm_out_t           res,
  input  logic                        cfg_we,
  input  bmm_pkg::bmm_reg_t           cfg_index,
  input  logic [bmm_pkg::CFG_W-1:0]   cfg_data
);
  import bmm_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0] w_last;
  logic [RW-1:0] h_last;
  logic          q_in_valid;
  logic          q_in_ready;
  bmm_item_t     q_in_item;
  logic          q_out_valid;
  logic          q_out_ready;
  bmm_item_t     q_out_item;

  function automatic logic [CW-1:0] width_last(input logic [WCFG_W-1:0] v);
    int unsigned x;
    x = 32'(v);
    if (x < 2) x = 2;
    if (x > MAX_WIDTH) x = MAX_WIDTH;
    return CW'(x - 1);
  endfunction

  function automatic logic [RW-1:0] height_last(input logic [HCFG_W-1:0] v);
    int unsigned x;
    x = 32'(v);
    if (x < 2) x = 2;
    if (x > MAX_HEIGHT) x = MAX_HEIGHT;
    return RW'(x - 1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last <= width_last(WIDTH_RESET);
      h_last <= height_last(HEIGHT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  w_last <= width_last(cfg_data[WCFG_W-1:0]);
        REG_IMAGE_HEIGHT: h_last <= height_last(cfg_data[HCFG_W-1:0]);
        default:          w_last <= w_last;
      endcase
    end
  end

  bmm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .pix        (pix),
    .w_last     (w_last),
    .h_last     (h_last),
    .item_valid (q_in_valid),
    .item_ready (q_in_ready),
    .item       (q_in_item)
  );

  bmm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_item  (q_in_item),
    .pop_valid  (q_out_valid),
    .pop_ready  (q_out_ready),
    .pop_item   (q_out_item)
  );

  bmm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_out_valid),
    .item_ready (q_out_ready),
    .item       (q_out_item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

endmodule

// ===== hw/rtl/bmm_front.sv =====
// front end: position tracking, line buffer, window and result classification
module bmm_front #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pix_valid,
  output logic                            pix_ready,
  input  bmm_pkg::bmm_in_t                pix,
  input  logic [$clog2(MAX_WIDTH)-1:0]    w_last,
  input  logic [$clog2(MAX_HEIGHT)-1:0]   h_last,
  output logic                            item_valid,
  input  logic                            item_ready,
  output bmm_pkg::bmm_item_t              item
);
  import bmm_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0]      col_cnt;
  logic [RW-1:0]      row_cnt;
  logic [CW-1:0]      base_c;
  logic [RW-1:0]      base_r;
  logic [RW:0]        r_inc;
  logic [CW-1:0]      c_pos;
  logic [RW-1:0]      r_pos;
  logic               accept;
  logic               push;

  logic               b_valid;
  logic [PIX_W-1:0]   b_px;
  logic [CW-1:0]      b_c;
  logic [RW-1:0]      b_r;

  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data;
  logic [2*PIX_W-1:0] wr_data;

  bmm_window_t        window;
  bmm_window_t        window_next;
  logic               has_row;
  logic               has_col;
  logic               edge_col;
  logic               last_row;

  assign accept     = pix_valid && pix_ready;
  assign push       = b_valid && item_ready;
  assign pix_ready  = !b_valid || item_ready;
  assign item_valid = b_valid;

  // position of the incoming pixel
  always_comb begin
    base_c = pix.frame_start ? '0 : col_cnt;
    base_r = pix.frame_start ? '0 : row_cnt;
    c_pos  = base_c;
    r_inc  = {1'b0, base_r};
    if (base_c > w_last) begin
      c_pos = '0;
      r_inc = {1'b0, base_r} + (RW+1)'(1);
    end
    r_pos = (r_inc > {1'b0, h_last}) ? '0 : r_inc[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
      b_valid <= 1'b0;
    end else begin
      if (accept) begin
        b_valid <= 1'b1;
        if (c_pos == w_last) begin
          col_cnt <= '0;
          row_cnt <= (r_pos == h_last) ? '0 : r_pos + RW'(1);
        end else begin
          col_cnt <= c_pos + CW'(1);
          row_cnt <= r_pos;
        end
      end else if (push) begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_px <= pix.pixel;
      b_c  <= c_pos;
      b_r  <= r_pos;
    end
  end

  // line buffer entry: older row in the upper byte, recent row in the lower
  assign wr_data = {rd_data[PIX_W-1:0], b_px};

  always_ff @(posedge clk) begin
    if (push) begin
      line_mem[b_c] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (push && (b_c == c_pos)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= line_mem[c_pos];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      window_next[i][0] = window[i][1];
      window_next[i][1] = window[i][2];
    end
    window_next[0][2] = rd_data[2*PIX_W-1:PIX_W];
    window_next[1][2] = rd_data[PIX_W-1:0];
    window_next[2][2] = b_px;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      window <= window_next;
    end
  end

  assign has_row  = (b_r != '0);
  assign has_col  = (b_c != '0);
  assign edge_col = (b_c == w_last);
  assign last_row = (b_r == h_last);

  always_comb begin
    item.window                 = window_next;
    item.row_cur                = ROW_W'(b_r);
    item.row_prev               = ROW_W'(b_r - RW'(1));
    item.col_cur                = COL_W'(b_c);
    item.col_prev               = COL_W'(b_c - CW'(1));
    item.top_mirror             = (b_r == RW'(1));
    item.left_mirror            = (b_c == CW'(1));
    item.res_mask               = '0;
    item.res_mask[RES_UP_LEFT]   = has_row && has_col;
    item.res_mask[RES_UP_EDGE]   = has_row && edge_col;
    item.res_mask[RES_LAST_LEFT] = last_row && has_col;
    item.res_mask[RES_LAST_EDGE] = last_row && edge_col;
  end

endmodule

// ===== hw/rtl/bmm_queue.sv =====
// two-entry queue of classified items between front and back
module bmm_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  bmm_pkg::bmm_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output bmm_pkg::bmm_item_t pop_item
);
  import bmm_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned AW    = $clog2(Depth);

  bmm_item_t     slots [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != (AW+1)'(Depth));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/bmm_back.sv =====
// back end: window sum then mean by reciprocal, one result per cycle unless res_ready stalls the output
module bmm_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  bmm_pkg::bmm_item_t item,
  output logic               res_valid,
  input  logic               res_ready,
  output bmm_pkg::bmm_out_t  res
);
  import bmm_pkg::*;

  bmm_item_t            cur;
  logic [RES_KINDS-1:0] cur_mask;
  logic [RES_KINDS-1:0] pick;
  logic [RES_KINDS-1:0] remain;
  logic                 emit;
  logic                 pop;
  logic                 s_load;
  logic                 o_ready;

  logic                 s_valid;
  logic [SUM_W-1:0]     s_sum;
  logic [ROW_W-1:0]     s_row;
  logic [COL_W-1:0]     s_col;
  logic                 s_last;

  logic [1:0]           rsel [3];
  logic [1:0]           csel [3];
  logic [SUM_W-1:0]     sum;
  logic [ROW_W-1:0]     sel_row;
  logic [COL_W-1:0]     sel_col;
  logic                 upper;
  logic                 leftish;
  logic [PROD_W-1:0]    product;

  assign o_ready    = !res_valid || res_ready;
  assign s_load     = !s_valid || o_ready;
  assign emit       = s_load && (cur_mask != '0);
  assign remain     = cur_mask & ~pick;
  assign pop        = item_valid && ((cur_mask == '0) || (emit && (remain == '0)));
  assign item_ready = pop;

  // lowest pending result kind goes first
  always_comb begin
    pick = '0;
    priority if (cur_mask[RES_UP_LEFT]) begin
      pick[RES_UP_LEFT] = 1'b1;
    end else if (cur_mask[RES_UP_EDGE]) begin
      pick[RES_UP_EDGE] = 1'b1;
    end else if (cur_mask[RES_LAST_LEFT]) begin
      pick[RES_LAST_LEFT] = 1'b1;
    end else if (cur_mask[RES_LAST_EDGE]) begin
      pick[RES_LAST_EDGE] = 1'b1;
    end else begin
      pick = '0;
    end
  end

  always_comb begin
    upper   = pick[RES_UP_LEFT] || pick[RES_UP_EDGE];
    leftish = pick[RES_UP_LEFT] || pick[RES_LAST_LEFT];
    sel_row = upper ? cur.row_prev : cur.row_cur;
    sel_col = leftish ? cur.col_prev : cur.col_cur;
    // mirrored rows and columns reuse the neighbor two away
    if (upper) begin
      rsel[0] = cur.top_mirror ? 2'd2 : 2'd0;
      rsel[1] = 2'd1;
      rsel[2] = 2'd2;
    end else begin
      rsel[0] = 2'd1;
      rsel[1] = 2'd2;
      rsel[2] = 2'd1;
    end
    if (leftish) begin
      csel[0] = cur.left_mirror ? 2'd2 : 2'd0;
      csel[1] = 2'd1;
      csel[2] = 2'd2;
    end else begin
      csel[0] = 2'd1;
      csel[1] = 2'd2;
      csel[2] = 2'd1;
    end
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sum = sum + SUM_W'(cur.window[rsel[i]][csel[j]]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask <= '0;
      s_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_mask <= item.res_mask;
      end else if (emit) begin
        cur_mask <= remain;
      end
      if (s_load) begin
        s_valid <= emit;
      end
      if (o_ready) begin
        res_valid <= s_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= item;
    end
    if (emit) begin
      s_sum  <= sum;
      s_row  <= sel_row;
      s_col  <= sel_col;
      s_last <= (remain == '0);
    end
  end

  assign product = PROD_W'(s_sum) * PROD_W'(MEAN_RECIP);

  always_ff @(posedge clk) begin
    if (o_ready && s_valid) begin
      res.mean_value  <= product[MEAN_LSB +: PIX_W];
      res.out_row     <= s_row;
      res.out_col     <= s_col;
      res.last_of_run <= s_last;
    end
  end

endmodule
